/* rtl/core/gwsp_pkg.sv */
// ----------------------------------------------------------------------------
// gwsp_pkg
// Shared constants and types for the weighted grid shortest-path block.
// ----------------------------------------------------------------------------
package gwsp_pkg;

  // Default sizes
  localparam int unsigned DEF_MAX_ROWS    = 64;
  localparam int unsigned DEF_MAX_COLS    = 64;
  localparam int unsigned DEF_QUEUE_DEPTH = 16384;

  // Configuration port
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAVY_COST = 3'd6;

  // Register reset values
  localparam logic [6:0]  RST_GRID_DIM   = 7'd64;
  localparam logic [11:0] RST_HEAVY_COST = 12'd2000;

  // Cell codes (anything else counts as open)
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_HEAVY = 2'd2;

  // Result field widths
  localparam int unsigned         DIST_OUT_W   = 24;
  localparam int unsigned         HEAVY_OUT_W  = 13;
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = 24'hFFFFFF;

  // Priority queue command and status
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } hq_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } hq_stat_t;

endpackage

/* rtl/core/gwsp_heap.sv */
// ----------------------------------------------------------------------------
// gwsp_heap
// Binary min-heap in a single-port-write, registered-read memory. Push sifts
// up (read parent, compare), pop sifts down (read left, read right, compare).
// ----------------------------------------------------------------------------
module gwsp_heap
  import gwsp_pkg::*;
#(
  parameter int unsigned DEPTH   = DEF_QUEUE_DEPTH,
  parameter int unsigned ENTRY_W = 36
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hq_cmd_t            cmd_i,
  input  logic [ENTRY_W-1:0] push_entry_i,
  output hq_stat_t           stat_o,
  output logic [ENTRY_W-1:0] pop_entry_o
);

  localparam int unsigned QW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = QW + 1;
  localparam int unsigned IX_W  = QW + 2;

  localparam logic [3:0] H_IDLE     = 4'd0;
  localparam logic [3:0] H_UP_RD    = 4'd1;
  localparam logic [3:0] H_UP_CMP   = 4'd2;
  localparam logic [3:0] H_POP_TOP  = 4'd3;
  localparam logic [3:0] H_POP_INIT = 4'd4;
  localparam logic [3:0] H_DN_L     = 4'd5;
  localparam logic [3:0] H_DN_R     = 4'd6;
  localparam logic [3:0] H_DN_CMP   = 4'd7;
  localparam logic [3:0] H_PLACE    = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [QW-1:0]      k_q, k_d;
  logic [ENTRY_W-1:0] item_q, item_d;
  logic [ENTRY_W-1:0] top_q, top_d;
  logic [ENTRY_W-1:0] lval_q, lval_d;

  logic [ENTRY_W-1:0] heap_mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               wr_en;
  logic [QW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [QW-1:0]      rd_addr;

  logic [QW-1:0]      up_w;
  logic [IX_W-1:0]    l_w, r_w;
  logic               take_l, take_r;
  logic [ENTRY_W-1:0] best_w;

  // Heap storage
  always_ff @(posedge clk_i) begin
    if (wr_en) heap_mem_q[wr_addr] <= wr_data;
    rd_data_q <= heap_mem_q[rd_addr];
  end

  // Index arithmetic
  assign up_w   = QW'((k_q - 1'b1) >> 1);
  assign l_w    = (IX_W'(k_q) << 1) + IX_W'(1);
  assign r_w    = l_w + IX_W'(1);
  assign take_l = (lval_q < item_q);
  assign best_w = take_l ? lval_q : item_q;
  assign take_r = (r_w < IX_W'(cnt_q)) && (rd_data_q < best_w);

  // Sift control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    item_d  = item_q;
    top_d   = top_q;
    lval_d  = lval_q;
    wr_en   = 1'b0;
    wr_addr = k_q;
    wr_data = item_q;
    rd_addr = '0;
    case (state_q)
      H_IDLE: begin
        if (cmd_i.clear) begin
          cnt_d = '0;
        end else if (cmd_i.push) begin
          if (cnt_q != CNT_W'(DEPTH)) begin
            item_d = push_entry_i;
            k_d    = cnt_q[QW-1:0];
            cnt_d  = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = push_entry_i;
            end else begin
              state_d = H_UP_RD;
            end
          end
        end else if (cmd_i.pop && (cnt_q != '0)) begin
          rd_addr = '0;
          state_d = H_POP_TOP;
        end
      end
      H_UP_RD: begin
        rd_addr = up_w;
        state_d = H_UP_CMP;
      end
      H_UP_CMP: begin
        wr_en = 1'b1;
        if (item_q < rd_data_q) begin
          wr_data = rd_data_q;
          k_d     = up_w;
          state_d = (up_w == '0) ? H_PLACE : H_UP_RD;
        end else begin
          state_d = H_IDLE;
        end
      end
      H_POP_TOP: begin
        top_d   = rd_data_q;
        rd_addr = QW'(cnt_q - 1'b1);
        cnt_d   = cnt_q - 1'b1;
        state_d = H_POP_INIT;
      end
      H_POP_INIT: begin
        item_d  = rd_data_q;
        k_d     = '0;
        state_d = (cnt_q == '0) ? H_IDLE : H_DN_L;
      end
      H_DN_L: begin
        if (l_w >= IX_W'(cnt_q)) begin
          state_d = H_PLACE;
        end else begin
          rd_addr = l_w[QW-1:0];
          state_d = H_DN_R;
        end
      end
      H_DN_R: begin
        lval_d  = rd_data_q;
        rd_addr = r_w[QW-1:0];
        state_d = H_DN_CMP;
      end
      H_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_data_q;
          k_d     = r_w[QW-1:0];
          state_d = H_DN_L;
        end else if (take_l) begin
          wr_data = lval_q;
          k_d     = l_w[QW-1:0];
          state_d = H_DN_L;
        end else begin
          state_d = H_IDLE;
        end
      end
      H_PLACE: begin
        wr_en   = 1'b1;
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    item_q <= item_d;
    top_q  <= top_d;
    lval_q <= lval_d;
  end

  assign stat_o.busy  = (state_q != H_IDLE);
  assign stat_o.empty = (cnt_q == '0);
  assign pop_entry_o  = top_q;

endmodule

/* rtl/core/gwsp_engine.sv */
// ----------------------------------------------------------------------------
// gwsp_engine
// Cell loader, per-cell node memory and the search sequencer: clearing pass,
// pop / relax loop against the heap, then the parent trace.
// ----------------------------------------------------------------------------
module gwsp_engine
  import gwsp_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS    = DEF_MAX_COLS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_valid_i,
  input  logic [1:0]             cell_kind_i,
  input  logic                   last_cell_i,
  input  logic [6:0]             grid_rows_i,
  input  logic [6:0]             grid_cols_i,
  input  logic [5:0]             start_row_i,
  input  logic [5:0]             start_col_i,
  input  logic [5:0]             target_row_i,
  input  logic [5:0]             target_col_i,
  input  logic [11:0]            heavy_cost_i,
  input  logic                   res_ready_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output logic                   res_reachable_o,
  output logic [DIST_OUT_W-1:0]  res_distance_o,
  output logic [HEAVY_OUT_W-1:0] res_heavy_o
);

  localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
  localparam int unsigned CW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned MAXDIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned DW     = $clog2(((MAXDIM > 127) ? MAXDIM : 127) + 1);
  localparam int unsigned DIST_W = CW + 12;
  localparam int unsigned PAR_W  = CW + 1;
  localparam int unsigned NODE_W = 1 + DIST_W + PAR_W;
  localparam int unsigned ENT_W  = DIST_W + RW + CLW;
  localparam int unsigned XW     = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;
  localparam int unsigned HX     = (PAR_W > HEAVY_OUT_W) ? PAR_W : HEAVY_OUT_W;

  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_CLR   = 4'd1;
  localparam logic [3:0] E_SEED  = 4'd2;
  localparam logic [3:0] E_SEEDW = 4'd3;
  localparam logic [3:0] E_POP   = 4'd4;
  localparam logic [3:0] E_POPW  = 4'd5;
  localparam logic [3:0] E_IDX   = 4'd6;
  localparam logic [3:0] E_RDI   = 4'd7;
  localparam logic [3:0] E_CHK   = 4'd8;
  localparam logic [3:0] E_NB    = 4'd9;
  localparam logic [3:0] E_NBCHK = 4'd10;
  localparam logic [3:0] E_PUSHW = 4'd11;
  localparam logic [3:0] E_TR    = 4'd12;
  localparam logic [3:0] E_TRCHK = 4'd13;
  localparam logic [3:0] E_DONE  = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     load_idx_q, load_idx_d;
  logic [CW-1:0]     clr_idx_q, clr_idx_d;
  logic [DW-1:0]     rows_q, rows_d, cols_q, cols_d;
  logic [CW-1:0]     s_q, s_d, i_q, i_d, n_q, n_d, cur_q, cur_d;
  logic [RW-1:0]     sr_q, sr_d, tr_q, tr_d, r_q, r_d, nr_q, nr_d;
  logic [CLW-1:0]    sc_q, sc_d, tc_q, tc_d, c_q, c_d, nc_q, nc_d;
  logic [DIST_W-1:0] d_q, d_d;
  logic [1:0]        k_q, k_d;
  logic              found_q, found_d;
  logic [PAR_W-1:0]  heavy_q, heavy_d, steps_q, steps_d;

  // Memories
  logic [1:0]        cell_mem_q [CELLS];
  logic [NODE_W-1:0] node_mem_q [CELLS];
  logic [1:0]        cell_rd_q;
  logic [NODE_W-1:0] node_rd_q;
  logic              cell_we, node_we;
  logic [CW-1:0]     cell_raddr, node_raddr, node_waddr;
  logic [NODE_W-1:0] node_wdata;

  // Heap link
  hq_cmd_t           hq_cmd;
  hq_stat_t          hq_stat;
  logic [ENT_W-1:0]  hq_push, hq_pop;

  // Combinational helpers
  logic              rd_reached;
  logic [DIST_W-1:0] rd_dist, nd_w;
  logic [PAR_W-1:0]  rd_par;
  logic              nb_ok;
  logic [CW-1:0]     nb_idx;
  logic [RW-1:0]     nb_row;
  logic [CLW-1:0]    nb_col;
  logic              oob_w;
  logic [DW-1:0]     gr_w, gc_w;
  logic [XW-1:0]     dist_x;
  logic [HX-1:0]     heavy_x;

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem_q[load_idx_q] <= cell_kind_i;
    cell_rd_q <= cell_mem_q[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem_q[node_waddr] <= node_wdata;
    node_rd_q <= node_mem_q[node_raddr];
  end

  gwsp_heap #(
    .DEPTH  (QUEUE_DEPTH),
    .ENTRY_W(ENT_W)
  ) u_heap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (hq_cmd),
    .push_entry_i(hq_push),
    .stat_o      (hq_stat),
    .pop_entry_o (hq_pop)
  );

  // Node word fields
  assign rd_reached = node_rd_q[NODE_W-1];
  assign rd_dist    = node_rd_q[NODE_W-2 -: DIST_W];
  assign rd_par     = node_rd_q[PAR_W-1:0];

  // Relaxed cost into the neighbour just read
  assign nd_w = d_q + ((cell_rd_q == KIND_HEAVY) ? DIST_W'(heavy_cost_i) : DIST_W'(1));

  // Grid size, widened; it is clamped when the last cell is loaded
  assign gr_w = DW'(grid_rows_i);
  assign gc_w = DW'(grid_cols_i);

  // Start or target outside the grid
  assign oob_w = (DW'(start_row_i) >= rows_q) || (DW'(start_col_i) >= cols_q) ||
                 (DW'(target_row_i) >= rows_q) || (DW'(target_col_i) >= cols_q);

  // Neighbour order: up, right, down, left
  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = i_q;
    nb_row = r_q;
    nb_col = c_q;
    case (k_q)
      2'd0: begin
        nb_ok  = (r_q != '0);
        nb_idx = CW'(i_q - cols_q);
        nb_row = r_q - 1'b1;
      end
      2'd1: begin
        nb_ok  = ((DW'(c_q) + DW'(1)) < cols_q);
        nb_idx = i_q + 1'b1;
        nb_col = c_q + 1'b1;
      end
      2'd2: begin
        nb_ok  = ((DW'(r_q) + DW'(1)) < rows_q);
        nb_idx = CW'(i_q + cols_q);
        nb_row = r_q + 1'b1;
      end
      default: begin
        nb_ok  = (c_q != '0);
        nb_idx = i_q - 1'b1;
        nb_col = c_q - 1'b1;
      end
    endcase
  end

  // Search sequencer
  always_comb begin
    state_d    = state_q;
    load_idx_d = load_idx_q;
    clr_idx_d  = clr_idx_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    s_d        = s_q;
    i_d        = i_q;
    n_d        = n_q;
    cur_d      = cur_q;
    sr_d       = sr_q;
    sc_d       = sc_q;
    tr_d       = tr_q;
    tc_d       = tc_q;
    r_d        = r_q;
    c_d        = c_q;
    nr_d       = nr_q;
    nc_d       = nc_q;
    d_d        = d_q;
    k_d        = k_q;
    found_d    = found_q;
    heavy_d    = heavy_q;
    steps_d    = steps_q;
    cell_we    = 1'b0;
    cell_raddr = n_q;
    node_we    = 1'b0;
    node_waddr = clr_idx_q;
    node_wdata = '0;
    node_raddr = i_q;
    hq_cmd     = '0;
    hq_push    = {nd_w, nr_q, nc_q};
    res_valid_o = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (load_valid_i) begin
          cell_we = 1'b1;
          if (last_cell_i) begin
            load_idx_d   = '0;
            clr_idx_d    = '0;
            hq_cmd.clear = 1'b1;
            rows_d  = (gr_w == '0) ? DW'(1) :
                      ((gr_w > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : gr_w);
            cols_d  = (gc_w == '0) ? DW'(1) :
                      ((gc_w > DW'(MAX_COLS)) ? DW'(MAX_COLS) : gc_w);
            state_d = E_CLR;
          end else begin
            load_idx_d = (load_idx_q == CW'(CELLS - 1)) ? '0 : load_idx_q + 1'b1;
          end
        end
      end
      E_CLR: begin
        node_we   = 1'b1;
        clr_idx_d = clr_idx_q + 1'b1;
        sr_d      = RW'(start_row_i);
        sc_d      = CLW'(start_col_i);
        tr_d      = RW'(target_row_i);
        tc_d      = CLW'(target_col_i);
        s_d       = CW'(sr_q * cols_q + sc_q);
        found_d   = 1'b0;
        heavy_d   = '0;
        steps_d   = '0;
        if (clr_idx_q == CW'(CELLS - 1)) state_d = E_SEED;
      end
      E_SEED: begin
        if (oob_w) begin
          state_d = E_DONE;
        end else begin
          node_we     = 1'b1;
          node_waddr  = s_q;
          node_wdata  = {1'b1, {DIST_W{1'b0}}, {PAR_W{1'b0}}};
          hq_cmd.push = 1'b1;
          hq_push     = {{DIST_W{1'b0}}, sr_q, sc_q};
          state_d     = E_SEEDW;
        end
      end
      E_SEEDW: begin
        if (!hq_stat.busy) state_d = E_POP;
      end
      E_POP: begin
        if (hq_stat.empty) begin
          state_d = E_DONE;
        end else begin
          hq_cmd.pop = 1'b1;
          state_d    = E_POPW;
        end
      end
      E_POPW: begin
        if (!hq_stat.busy) begin
          d_d     = hq_pop[ENT_W-1 -: DIST_W];
          r_d     = hq_pop[RW+CLW-1 -: RW];
          c_d     = hq_pop[CLW-1:0];
          state_d = E_IDX;
        end
      end
      E_IDX: begin
        i_d     = CW'(r_q * cols_q + c_q);
        state_d = E_RDI;
      end
      E_RDI: begin
        node_raddr = i_q;
        state_d    = E_CHK;
      end
      E_CHK: begin
        if (d_q > rd_dist) begin
          state_d = E_POP;
        end else if ((r_q == tr_q) && (c_q == tc_q)) begin
          found_d = 1'b1;
          cur_d   = i_q;
          state_d = E_TR;
        end else begin
          k_d     = 2'd0;
          state_d = E_NB;
        end
      end
      E_NB: begin
        if (nb_ok) begin
          cell_raddr = nb_idx;
          node_raddr = nb_idx;
          n_d        = nb_idx;
          nr_d       = nb_row;
          nc_d       = nb_col;
          state_d    = E_NBCHK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = (k_q == 2'd3) ? E_POP : E_NB;
        end
      end
      E_NBCHK: begin
        if ((cell_rd_q != KIND_WALL) && (!rd_reached || (nd_w < rd_dist))) begin
          node_we     = 1'b1;
          node_waddr  = n_q;
          node_wdata  = {1'b1, nd_w, PAR_W'(i_q) + PAR_W'(1)};
          hq_cmd.push = 1'b1;
          state_d     = E_PUSHW;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = (k_q == 2'd3) ? E_POP : E_NB;
        end
      end
      E_PUSHW: begin
        if (!hq_stat.busy) begin
          k_d     = k_q + 1'b1;
          state_d = (k_q == 2'd3) ? E_POP : E_NB;
        end
      end
      E_TR: begin
        cell_raddr = cur_q;
        node_raddr = cur_q;
        state_d    = E_TRCHK;
      end
      E_TRCHK: begin
        if (cell_rd_q == KIND_HEAVY) heavy_d = heavy_q + 1'b1;
        steps_d = steps_q + 1'b1;
        cur_d   = CW'(rd_par - 1'b1);
        if ((rd_par == '0) || ((steps_q + 1'b1) == PAR_W'(CELLS))) state_d = E_DONE;
        else state_d = E_TR;
      end
      E_DONE: begin
        res_valid_o = res_ready_i;
        if (res_ready_i) state_d = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= E_IDLE;
      load_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_idx_q <= clr_idx_d;
    rows_q    <= rows_d;
    cols_q    <= cols_d;
    s_q       <= s_d;
    i_q       <= i_d;
    n_q       <= n_d;
    cur_q     <= cur_d;
    sr_q      <= sr_d;
    sc_q      <= sc_d;
    tr_q      <= tr_d;
    tc_q      <= tc_d;
    r_q       <= r_d;
    c_q       <= c_d;
    nr_q      <= nr_d;
    nc_q      <= nc_d;
    d_q       <= d_d;
    k_q       <= k_d;
    found_q   <= found_d;
    heavy_q   <= heavy_d;
    steps_q   <= steps_d;
  end

  // Result formatting: distance saturates, heavy count wraps
  assign dist_x  = XW'(d_q);
  assign heavy_x = HX'(heavy_q);

  assign busy_o          = (state_q != E_IDLE);
  assign res_reachable_o = found_q;
  assign res_distance_o  = !found_q ? '0 :
                           ((dist_x > XW'(DIST_OUT_MAX)) ? DIST_OUT_MAX : dist_x[DIST_OUT_W-1:0]);
  assign res_heavy_o     = found_q ? heavy_x[HEAVY_OUT_W-1:0] : '0;

endmodule

/* rtl/core/grid_weighted_shortest_path.sv */
// ----------------------------------------------------------------------------
// grid_weighted_shortest_path
// Loads a grid one cell per cycle, then runs a least-cost search from the
// start cell to the target and reports reachability, cost and heavy cells.
// ----------------------------------------------------------------------------
// Loading: one cell per cycle, no result except on the last cell.
// Search: a clearing pass over all MAX_ROWS*MAX_COLS node words, then per
//   queue pop a wait for the heap sift-down and a read of the popped node,
//   and per neighbour a read of its cell and node and, if relaxed, a push that
//   waits for the sift-up; the trace reads each path cell in turn. The result leaves through an output register.
// The input is stalled from the last cell until the result is handed over.
// Reset clears control state and restores register defaults; memories are not.
module grid_weighted_shortest_path
  import gwsp_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS    = DEF_MAX_COLS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Cell input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             cell_kind_i,
  input  logic                   last_cell_i,
  // Result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   reachable_o,
  output logic [DIST_OUT_W-1:0]  distance_o,
  output logic [HEAVY_OUT_W-1:0] heavy_on_path_o
);

  logic [6:0]  grid_rows_q, grid_cols_q;
  logic [5:0]  start_row_q, start_col_q, target_row_q, target_col_q;
  logic [11:0] heavy_cost_q;

  logic                   busy;
  logic                   in_take;
  logic                   res_valid, res_ready;
  logic                   res_reachable;
  logic [DIST_OUT_W-1:0]  res_distance;
  logic [HEAVY_OUT_W-1:0] res_heavy;

  logic                   out_valid_q, out_valid_d;
  logic                   reachable_q;
  logic [DIST_OUT_W-1:0]  distance_q;
  logic [HEAVY_OUT_W-1:0] heavy_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= RST_GRID_DIM;
      grid_cols_q  <= RST_GRID_DIM;
      start_row_q  <= '0;
      start_col_q  <= '0;
      target_row_q <= '0;
      target_col_q <= '0;
      heavy_cost_q <= RST_HEAVY_COST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_ROWS:  grid_rows_q  <= cfg_data_i[6:0];
        REG_GRID_COLS:  grid_cols_q  <= cfg_data_i[6:0];
        REG_START_ROW:  start_row_q  <= cfg_data_i[5:0];
        REG_START_COL:  start_col_q  <= cfg_data_i[5:0];
        REG_TARGET_ROW: target_row_q <= cfg_data_i[5:0];
        REG_TARGET_COL: target_col_q <= cfg_data_i[5:0];
        REG_HEAVY_COST: heavy_cost_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Input transaction
  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy;

  gwsp_engine #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_valid_i   (in_take),
    .cell_kind_i    (cell_kind_i),
    .last_cell_i    (last_cell_i),
    .grid_rows_i    (grid_rows_q),
    .grid_cols_i    (grid_cols_q),
    .start_row_i    (start_row_q),
    .start_col_i    (start_col_q),
    .target_row_i   (target_row_q),
    .target_col_i   (target_col_q),
    .heavy_cost_i   (heavy_cost_q),
    .res_ready_i    (res_ready),
    .busy_o         (busy),
    .res_valid_o    (res_valid),
    .res_reachable_o(res_reachable),
    .res_distance_o (res_distance),
    .res_heavy_o    (res_heavy)
  );

  // Output register
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      reachable_q <= res_reachable;
      distance_q  <= res_distance;
      heavy_q     <= res_heavy;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reachable_o     = reachable_q;
  assign distance_o      = distance_q;
  assign heavy_on_path_o = heavy_q;

endmodule

/* tb/sv/grid_weighted_shortest_path_test.sv */
// ----------------------------------------------------------------------------
// grid_weighted_shortest_path_test
// Loads grids cell by cell into the shortest-path block and checks each
// search result against a local least-cost search with parent tracing.
// ----------------------------------------------------------------------------
module grid_weighted_shortest_path_test;
  import gwsp_pkg::*;

  localparam int unsigned NCELLS    = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam logic [1:0]  KIND_OPEN = 2'd0;
  localparam logic [1:0]  KIND_ODD  = 2'd3;

  typedef struct packed {
    logic                   reachable;
    logic [DIST_OUT_W-1:0]  distance;
    logic [HEAVY_OUT_W-1:0] heavy;
  } path_result_t;

  logic                   clk_i, rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   in_valid_i, in_stall_o;
  logic [1:0]             cell_kind_i;
  logic                   last_cell_i;
  logic                   out_valid_o, out_stall_i;
  logic                   reachable_o;
  logic [DIST_OUT_W-1:0]  distance_o;
  logic [HEAVY_OUT_W-1:0] heavy_on_path_o;

  grid_weighted_shortest_path i_dut (.*);

  // Local copy of the block's registers and grid memory
  int unsigned  reg_rows, reg_cols, reg_srow, reg_scol, reg_trow, reg_tcol, reg_cost;
  logic [1:0]   grid_cell [NCELLS];
  bit           cell_written [NCELLS];
  int unsigned  load_pos;

  // Search scratch
  longint       node_dist [NCELLS];
  bit           node_seen [NCELLS];
  int unsigned  node_parent [NCELLS];
  longint       heap_dist [DEF_QUEUE_DEPTH];
  int unsigned  heap_cell [DEF_QUEUE_DEPTH];
  int unsigned  heap_len;

  path_result_t pending_paths [$];
  int           mismatches;
  int           cells_sent;
  bit           no_idle;
  int           hold_left;

  // Clock and run limit
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #240000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit heap_less(int unsigned a, int unsigned b);
    if (heap_dist[a] != heap_dist[b]) return heap_dist[a] < heap_dist[b];
    return heap_cell[a] < heap_cell[b];
  endfunction

  function automatic void heap_swap(int unsigned a, int unsigned b);
    longint      d;
    int unsigned c;
    d = heap_dist[a]; c = heap_cell[a];
    heap_dist[a] = heap_dist[b]; heap_cell[a] = heap_cell[b];
    heap_dist[b] = d; heap_cell[b] = c;
  endfunction

  function automatic void heap_push(longint d, int unsigned c);
    int unsigned k;
    if (heap_len >= DEF_QUEUE_DEPTH) return;
    k = heap_len;
    heap_len++;
    heap_dist[k] = d; heap_cell[k] = c;
    while (k > 0 && heap_less(k, (k - 1) / 2)) begin
      heap_swap(k, (k - 1) / 2);
      k = (k - 1) / 2;
    end
  endfunction

  function automatic void heap_pop(output longint d, output int unsigned c);
    int unsigned k, l, r, m;
    k = 0;
    d = heap_dist[0]; c = heap_cell[0];
    heap_len--;
    heap_dist[0] = heap_dist[heap_len]; heap_cell[0] = heap_cell[heap_len];
    forever begin
      l = 2 * k + 1; r = l + 1; m = k;
      if (l < heap_len && heap_less(l, m)) m = l;
      if (r < heap_len && heap_less(r, m)) m = r;
      if (m == k) break;
      heap_swap(k, m);
      k = m;
    end
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Least-cost search over the loaded grid, then heavy count along the parents
  function automatic path_result_t solve_grid();
    path_result_t res;
    int unsigned  rows, cols, s, t, cur, n, r, c, steps, heavy;
    int           nr, nc, k;
    longint       d, nd;
    bit           found;
    int           dr [4] = '{-1, 0, 1, 0};
    int           dc [4] = '{0, 1, 0, -1};
    res = '0;
    found = 1'b0;
    heavy = 0;
    rows = clamp_dim(reg_rows, DEF_MAX_ROWS);
    cols = clamp_dim(reg_cols, DEF_MAX_COLS);
    for (int i = 0; i < NCELLS; i++) begin
      node_dist[i] = 0; node_seen[i] = 1'b0; node_parent[i] = 0;
    end
    heap_len = 0;
    if (reg_srow >= rows || reg_scol >= cols || reg_trow >= rows || reg_tcol >= cols)
      return res;
    s = reg_srow * cols + reg_scol;
    t = reg_trow * cols + reg_tcol;
    node_seen[s] = 1'b1;
    heap_push(0, s);
    while (heap_len > 0) begin
      heap_pop(d, cur);
      if (d > node_dist[cur]) continue;
      if (cur == t) begin
        found = 1'b1;
        break;
      end
      r = cur / cols; c = cur % cols;
      for (k = 0; k < 4; k++) begin
        nr = int'(r) + dr[k]; nc = int'(c) + dc[k];
        if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
        n = nr * cols + nc;
        if (grid_cell[n] == KIND_WALL) continue;
        nd = d + ((grid_cell[n] == KIND_HEAVY) ? longint'(reg_cost) : 1);
        if (!node_seen[n] || nd < node_dist[n]) begin
          node_parent[n] = cur + 1;
          node_dist[n] = nd;
          node_seen[n] = 1'b1;
          heap_push(nd, n);
        end
      end
    end
    if (!found) return res;
    cur = t + 1;
    for (steps = 0; cur != 0 && steps < NCELLS; steps++) begin
      if (grid_cell[cur - 1] == KIND_HEAVY) heavy++;
      cur = node_parent[cur - 1];
    end
    res.reachable = 1'b1;
    res.distance  = (node_dist[t] > DIST_OUT_MAX) ? DIST_OUT_MAX : node_dist[t][23:0];
    res.heavy     = heavy[12:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // Result side: random stall, long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(0, 99) < 27);
      end
    end
  end

  // Result check: sampled mid-cycle, the transaction completes at the next edge
  initial begin
    path_result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_paths.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          want = pending_paths.pop_front();
          if (reachable_o !== want.reachable)
            report_mismatch("reachable", want.reachable, reachable_o);
          if (distance_o !== want.distance)
            report_mismatch("distance", want.distance, distance_o);
          if (heavy_on_path_o !== want.heavy)
            report_mismatch("heavy_on_path", want.heavy, heavy_on_path_o);
        end
      end
    end
  end

  // One cell transaction; the local store is updated once it is taken
  task automatic send_cell(logic [1:0] kind, bit last);
    bit taken;
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_kind_i <= kind;
    last_cell_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    cells_sent++;
    if (load_pos >= NCELLS) load_pos = 0;
    grid_cell[load_pos] = kind;
    cell_written[load_pos] = 1'b1;
    load_pos++;
    if (load_pos >= NCELLS) load_pos = 0;
    if (last) begin
      load_pos = 0;
      pending_paths.insert(pending_paths.size(), solve_grid());
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    case (idx)
      REG_GRID_ROWS:  reg_rows = val & 'h7F;
      REG_GRID_COLS:  reg_cols = val & 'h7F;
      REG_START_ROW:  reg_srow = val & 'h3F;
      REG_START_COL:  reg_scol = val & 'h3F;
      REG_TARGET_ROW: reg_trow = val & 'h3F;
      REG_TARGET_COL: reg_tcol = val & 'h3F;
      REG_HEAVY_COST: reg_cost = val & 'hFFF;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, int unsigned sr,
                           int unsigned sc, int unsigned tr, int unsigned tc,
                           int unsigned cost);
    wait_idle();
    put_reg(REG_GRID_ROWS, rows);
    put_reg(REG_GRID_COLS, cols);
    put_reg(REG_START_ROW, sr);
    put_reg(REG_START_COL, sc);
    put_reg(REG_TARGET_ROW, tr);
    put_reg(REG_TARGET_COL, tc);
    put_reg(REG_HEAVY_COST, cost);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Map text: O open, # wall, H heavy, X code three; last cell ends the grid
  task automatic send_map(string cells);
    logic [1:0] kind;
    for (int i = 0; i < cells.len(); i++) begin
      case (cells[i])
        "#":     kind = KIND_WALL;
        "H":     kind = KIND_HEAVY;
        "X":     kind = KIND_ODD;
        default: kind = KIND_OPEN;
      endcase
      send_cell(kind, i == cells.len() - 1);
    end
  endtask

  function automatic logic [1:0] random_kind();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 25) return KIND_WALL;
    if (p < 45) return KIND_HEAVY;
    if (p < 49) return KIND_ODD;
    return KIND_OPEN;
  endfunction

  task automatic send_random_cells(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cell(random_kind(), i == n - 1);
  endtask

  // Corner cases, mostly on small hand-made grids
  task automatic test_directed();
    configure(1, 1, 0, 0, 0, 0, 5);      // start is target, heavy cell
    send_map("H");
    configure(0, 0, 0, 0, 0, 0, 5);      // zero dimensions act as one
    send_map("O");
    configure(3, 3, 0, 0, 2, 2, 2000);
    send_map("OOOO#OOOO");
    configure(3, 3, 0, 0, 0, 2, 0);      // free heavy cells
    send_map("OHOOHOOOO");
    configure(3, 3, 0, 0, 0, 2, 4095);   // costly heavy cells, code three
    send_map("OHXXHOOOX");
    configure(1, 2, 0, 0, 0, 1, 7);      // target is a wall
    send_map("O#");
    configure(1, 3, 0, 0, 0, 2, 7);      // target walled off
    send_map("O#O");
    configure(2, 2, 63, 0, 1, 1, 7);     // start outside
    send_map("OOOO");
    configure(2, 2, 0, 0, 1, 63, 7);     // target outside
    send_map("OOOO");
    configure(127, 1, 0, 0, 63, 0, 3);   // rows clamp to the maximum
    send_random_cells(64);
    configure(1, 127, 0, 63, 0, 0, 3);
    send_random_cells(64);
  endtask

  // Tall grid using every row, from the bottom-right corner to the cell above it
  task automatic test_full_size();
    configure(64, 8, 63, 7, 62, 7, 9);
    send_random_cells(64 * 8);
  endtask

  // Receiver holds off across two searches while further grids are offered
  task automatic test_backpressure();
    configure(3, 3, 0, 0, 2, 2, 4);
    no_idle = 1'b1;
    hold_left = 12000;
    send_random_cells(9);
    send_random_cells(9);
    send_random_cells(9);
    no_idle = 1'b0;
  endtask

  task automatic test_random(int unsigned quota);
    int unsigned rows, cols, er, ec, total, n, grids;
    int unsigned sr, sc, tr, tc, cost;
    bit          covered;
    grids = 0;
    while (cells_sent < quota) begin
      grids++;
      no_idle = (grids >= 5 && grids < 12);
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 6);
      case ($urandom_range(0, 15))
        0: begin rows = 0; cols = $urandom_range(1, 8); end
        1: begin rows = $urandom_range(64, 127); cols = $urandom_range(1, 2); end
        2: begin cols = $urandom_range(64, 127); rows = 1; end
        3: begin rows = $urandom_range(8, 12); cols = $urandom_range(8, 12); end
        default: ;
      endcase
      er = clamp_dim(rows, DEF_MAX_ROWS);
      ec = clamp_dim(cols, DEF_MAX_COLS);
      sr = $urandom_range(0, er - 1); sc = $urandom_range(0, ec - 1);
      tr = $urandom_range(0, er - 1); tc = $urandom_range(0, ec - 1);
      if ($urandom_range(0, 99) < 8) sr = $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 8) tc = $urandom_range(0, 63);
      case ($urandom_range(0, 7))
        0:       cost = 0;
        1:       cost = 4095;
        2, 3:    cost = $urandom_range(1, 4095);
        default: cost = $urandom_range(1, 6);
      endcase
      configure(rows, cols, sr, sc, tr, tc, cost);
      total = er * ec;
      n = total;
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: early end over already written cells, or extras
        n = $urandom_range(1, total);
        covered = 1'b1;
        for (int unsigned i = n; i < total; i++) covered &= cell_written[i];
        if (!covered) n = total + $urandom_range(1, 5);
      end
      send_random_cells(n);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; cell_kind_i = '0; last_cell_i = 1'b0;
    mismatches = 0; cells_sent = 0; no_idle = 1'b0; hold_left = 0;
    reg_rows = RST_GRID_DIM; reg_cols = RST_GRID_DIM;
    reg_srow = 0; reg_scol = 0; reg_trow = 0; reg_tcol = 0;
    reg_cost = RST_HEAVY_COST;
    load_pos = 0;
    for (int i = 0; i < NCELLS; i++) begin
      grid_cell[i] = KIND_OPEN;
      cell_written[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_size();
    test_backpressure();
    test_random(1150);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gwsp_pkg.sv
rtl/core/gwsp_heap.sv
rtl/core/gwsp_engine.sv
rtl/core/grid_weighted_shortest_path.sv
tb/sv/grid_weighted_shortest_path_test.sv
